// File: rtl/fpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware packet checker package
// Shared sizes, frame layout constants, reply codes, the queue entry type and
// the per-byte CRC and pattern functions.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int BUFFER_BYTES     = 1024;
  localparam int PAGE_BYTES       = 256;
  localparam int PAGES_PER_SECTOR = 8;
  localparam int ADDR_BITS        = 20;

  localparam int IDX_W     = $clog2(BUFFER_BYTES + 1);
  localparam int PC_W      = $clog2(PAGES_PER_SECTOR + 1);
  localparam int WADDR_W   = 20;
  localparam int PAY_START = 7;
  localparam int CRC_POS   = PAY_START + PAGE_BYTES;
  localparam int FRAME_MIN = CRC_POS + 2;
  localparam int INIT_LEN  = 10;
  localparam int ACT_LEN   = 7;
  localparam int HDR_LEN   = 3;
  localparam int PAT_W     = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int MATCH_INIT = 0;
  localparam int MATCH_ACT  = 1;
  localparam int MATCH_HDR  = 2;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_REJ  = 2'd2
  } reply_t;

  // One entry handed from the front end to the sequencer.
  typedef struct packed {
    logic        is_flash;
    logic        flash_ok;
    logic        init_ok;
    logic        act_ok;
    logic        hdr_ok;
    logic        crc_ok;
    logic [15:0] packet_number;
    logic [15:0] remaining_count;
  } fpc_job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] init_byte(input logic [PAT_W-1:0] i);
    logic [7:0] v;
    case (i)
      4'd0:    v = 8'h02;
      4'd1:    v = 8'h0E;
      4'd2:    v = 8'h01;
      4'd3:    v = 8'h02;
      4'd4:    v = 8'hFA;
      4'd5:    v = 8'h01;
      4'd6:    v = 8'h01;
      4'd7:    v = 8'h2C;
      4'd8:    v = 8'hDD;
      4'd9:    v = 8'h03;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] act_byte(input logic [PAT_W-1:0] i);
    logic [7:0] v;
    case (i)
      4'd0:    v = 8'h02;
      4'd1:    v = 8'h00;
      4'd2:    v = 8'h04;
      4'd3:    v = 8'hAA;
      4'd4:    v = 8'h00;
      4'd5:    v = 8'h00;
      4'd6:    v = 8'h03;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [PAT_W-1:0] i);
    logic [7:0] v;
    case (i)
      4'd0:    v = 8'h02;
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h07;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/fpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware packet checker channel interfaces
// Valid/ready channels for input beats, result beats and the configuration write.
// ----------------------------------------------------------------------------
interface fpc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       flash_ok;
  modport source(output valid, func, data_byte, last_byte, flash_ok, input ready);
  modport sink(input valid, func, data_byte, last_byte, flash_ok, output ready);
endinterface

interface fpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_code;
  logic        write_request;
  logic        write_erase;
  logic [19:0] write_address;
  logic        reset_request;
  logic        update_closed;
  modport source(output valid, reply_code, write_request, write_erase, write_address,
                 reset_request, update_closed, input ready);
  modport sink(input valid, reply_code, write_request, write_erase, write_address,
               reset_request, update_closed, output ready);
endinterface

interface fpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] start_address;
  modport source(output valid, start_address, input ready);
  modport sink(input valid, start_address, output ready);
endinterface
`default_nettype wire

// File: rtl/fpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware packet checker front end
// Accepts beats, runs pattern matching, field capture and the payload CRC,
// and hands one entry per frame end or flash event to the queue.
// ----------------------------------------------------------------------------
module fpc_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  fpc_in_if.sink            in_bus,
  input  wire logic         q_full,
  output logic              job_valid,
  output fpc_pkg::fpc_job_t job
);

  logic [fpc_pkg::IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [15:0]               crc_r, crc_nxt;
  logic [2:0]                flags_r, flags_nxt;
  logic [15:0]               pn_r, pn_nxt;
  logic [15:0]               rc_r, rc_nxt;
  logic [15:0]               rcrc_r, rcrc_nxt;

  logic                      in_acc;
  logic                      frame_first;
  logic [fpc_pkg::PAT_W-1:0] pidx;
  logic [7:0]                b;

  assign in_bus.ready = !q_full;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign frame_first  = (byte_index_r == '0);
  assign pidx         = byte_index_r[fpc_pkg::PAT_W-1:0];
  assign b            = in_bus.data_byte;

  always_comb begin
    // A new frame starts from cleared capture state.
    crc_nxt        = frame_first ? fpc_pkg::CRC_INIT : crc_r;
    flags_nxt      = frame_first ? 3'b111 : flags_r;
    pn_nxt         = frame_first ? 16'h0000 : pn_r;
    rc_nxt         = frame_first ? 16'h0000 : rc_r;
    rcrc_nxt       = frame_first ? 16'h0000 : rcrc_r;
    byte_index_nxt = byte_index_r;

    if (byte_index_r < fpc_pkg::IDX_W'(fpc_pkg::BUFFER_BYTES)) begin
      if (byte_index_r < fpc_pkg::IDX_W'(fpc_pkg::INIT_LEN) &&
          b != fpc_pkg::init_byte(pidx)) begin
        flags_nxt[fpc_pkg::MATCH_INIT] = 1'b0;
      end
      if (byte_index_r < fpc_pkg::IDX_W'(fpc_pkg::ACT_LEN) &&
          b != fpc_pkg::act_byte(pidx)) begin
        flags_nxt[fpc_pkg::MATCH_ACT] = 1'b0;
      end
      if (byte_index_r < fpc_pkg::IDX_W'(fpc_pkg::HDR_LEN) &&
          b != fpc_pkg::hdr_byte(pidx)) begin
        flags_nxt[fpc_pkg::MATCH_HDR] = 1'b0;
      end
      if (byte_index_r == fpc_pkg::IDX_W'(3)) pn_nxt = {b, 8'h00};
      if (byte_index_r == fpc_pkg::IDX_W'(4)) pn_nxt = {pn_nxt[15:8], b};
      if (byte_index_r == fpc_pkg::IDX_W'(5)) rc_nxt = {b, 8'h00};
      if (byte_index_r == fpc_pkg::IDX_W'(6)) rc_nxt = {rc_nxt[15:8], b};
      if (byte_index_r >= fpc_pkg::IDX_W'(fpc_pkg::PAY_START) &&
          byte_index_r < fpc_pkg::IDX_W'(fpc_pkg::CRC_POS)) begin
        crc_nxt = fpc_pkg::crc_byte(crc_nxt, b);
      end
      if (byte_index_r == fpc_pkg::IDX_W'(fpc_pkg::CRC_POS)) rcrc_nxt = {b, 8'h00};
      if (byte_index_r == fpc_pkg::IDX_W'(fpc_pkg::CRC_POS + 1)) begin
        rcrc_nxt = {rcrc_nxt[15:8], b};
      end
      byte_index_nxt = byte_index_r + 1'b1;
    end
  end

  always_comb begin
    job_valid           = in_acc && (in_bus.func || in_bus.last_byte);
    job.is_flash        = in_bus.func;
    job.flash_ok        = in_bus.flash_ok;
    job.init_ok         = flags_nxt[fpc_pkg::MATCH_INIT] &&
                          byte_index_nxt >= fpc_pkg::IDX_W'(fpc_pkg::INIT_LEN);
    job.act_ok          = flags_nxt[fpc_pkg::MATCH_ACT] &&
                          byte_index_nxt >= fpc_pkg::IDX_W'(fpc_pkg::ACT_LEN);
    job.hdr_ok          = flags_nxt[fpc_pkg::MATCH_HDR] &&
                          byte_index_nxt >= fpc_pkg::IDX_W'(fpc_pkg::HDR_LEN);
    job.crc_ok          = byte_index_nxt >= fpc_pkg::IDX_W'(fpc_pkg::FRAME_MIN) &&
                          rcrc_nxt == crc_nxt;
    job.packet_number   = pn_nxt;
    job.remaining_count = rc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
    end else if (in_acc && !in_bus.func) begin
      byte_index_r <= in_bus.last_byte ? '0 : byte_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !in_bus.func) begin
      crc_r   <= crc_nxt;
      flags_r <= flags_nxt;
      pn_r    <= pn_nxt;
      rc_r    <= rc_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= fpc_pkg::IDX_W'(fpc_pkg::BUFFER_BYTES))
    else $error("frame byte index beyond buffer size");
`endif

endmodule
`default_nettype wire

// File: rtl/fpc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware packet checker queue
// Two-entry register queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module fpc_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  fpc_pkg::fpc_job_t push_job,
  output logic              full,
  output logic              pop_valid,
  output fpc_pkg::fpc_job_t pop_job,
  input  wire logic         pop
);

  fpc_pkg::fpc_job_t mem_r [2];
  logic [1:0]        count_r, count_nxt;
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_job   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 2'd1;
    if (!do_push && do_pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("entry pushed into a full queue");
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r))
    else $error("queue count disagrees with pointers");
`endif

endmodule
`default_nettype wire

// File: rtl/fpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware packet checker sequencer
// Holds the update session state, decides the reply for each queued entry and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module fpc_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         job_valid,
  input  fpc_pkg::fpc_job_t job,
  output logic              pop,
  fpc_out_if.source         out_bus,
  fpc_cfg_if.sink           cfg_bus
);

  logic [15:0]                   exp_num_r, exp_num_nxt;
  logic [fpc_pkg::ADDR_BITS-1:0] page_addr_r, page_addr_nxt;
  logic [fpc_pkg::PC_W-1:0]      page_count_r, page_count_nxt;
  logic [fpc_pkg::PC_W-1:0]      pc_inc;
  logic                          done_r, done_nxt;
  logic                          pend_erase_r, pend_erase_nxt;

  logic                          out_valid_r;
  logic [1:0]                    reply_r, reply_nxt;
  logic                          wr_req_r, wr_req_nxt;
  logic                          wr_erase_r, wr_erase_nxt;
  logic [fpc_pkg::WADDR_W-1:0]   wr_addr_r, wr_addr_nxt;
  logic                          rst_req_r, rst_req_nxt;
  logic                          closed_r, closed_nxt;

  assign pop          = job_valid && (!out_valid_r || out_bus.ready);
  assign cfg_bus.ready = 1'b1;
  assign pc_inc       = page_count_r + 1'b1;

  always_comb begin
    exp_num_nxt    = exp_num_r;
    page_addr_nxt  = page_addr_r;
    page_count_nxt = page_count_r;
    done_nxt       = done_r;
    pend_erase_nxt = pend_erase_r;
    reply_nxt      = fpc_pkg::REPLY_NONE;
    wr_req_nxt     = 1'b0;
    wr_erase_nxt   = 1'b0;
    wr_addr_nxt    = '0;
    rst_req_nxt    = 1'b0;
    closed_nxt     = 1'b0;

    if (job.is_flash) begin
      if (job.flash_ok) begin
        reply_nxt = fpc_pkg::REPLY_ACK;
      end else begin
        reply_nxt = fpc_pkg::REPLY_REJ;
        if (pend_erase_r) page_count_nxt = '0;
      end
      pend_erase_nxt = 1'b0;
    end else if (job.init_ok) begin
      reply_nxt   = done_r ? fpc_pkg::REPLY_REJ : fpc_pkg::REPLY_NONE;
      rst_req_nxt = 1'b1;
    end else if (job.act_ok) begin
      if (done_r) begin
        reply_nxt   = fpc_pkg::REPLY_ACK;
        rst_req_nxt = 1'b1;
      end else begin
        reply_nxt      = fpc_pkg::REPLY_REJ;
        page_count_nxt = '0;
      end
    end else if ((job.hdr_ok && job.packet_number != exp_num_r) || !job.crc_ok) begin
      reply_nxt      = fpc_pkg::REPLY_REJ;
      page_count_nxt = '0;
    end else begin
      // First page of each sector group also erases the sector.
      wr_req_nxt     = 1'b1;
      wr_erase_nxt   = (pc_inc == fpc_pkg::PC_W'(1));
      pend_erase_nxt = wr_erase_nxt;
      page_count_nxt = (pc_inc >= fpc_pkg::PC_W'(fpc_pkg::PAGES_PER_SECTOR)) ? '0 : pc_inc;
      wr_addr_nxt    = fpc_pkg::WADDR_W'(page_addr_r);
      page_addr_nxt  = page_addr_r + fpc_pkg::ADDR_BITS'(fpc_pkg::PAGE_BYTES);
      exp_num_nxt    = exp_num_r + 16'd1;
      if (job.remaining_count == 16'h0000) begin
        done_nxt   = 1'b1;
        closed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_num_r    <= 16'd1;
      page_addr_r  <= '0;
      page_count_r <= '0;
      done_r       <= 1'b0;
      pend_erase_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        exp_num_r    <= exp_num_nxt;
        page_addr_r  <= page_addr_nxt;
        page_count_r <= page_count_nxt;
        done_r       <= done_nxt;
        pend_erase_r <= pend_erase_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      // Configuration must come only while idle, not with a pop; not enforced.
      if (cfg_bus.valid) begin
        page_addr_r <= fpc_pkg::ADDR_BITS'(cfg_bus.start_address);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      reply_r    <= reply_nxt;
      wr_req_r   <= wr_req_nxt;
      wr_erase_r <= wr_erase_nxt;
      wr_addr_r  <= wr_addr_nxt;
      rst_req_r  <= rst_req_nxt;
      closed_r   <= closed_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.reply_code    = reply_r;
  assign out_bus.write_request = wr_req_r;
  assign out_bus.write_erase   = wr_erase_r;
  assign out_bus.write_address = wr_addr_r;
  assign out_bus.reset_request = rst_req_r;
  assign out_bus.update_closed = closed_r;

`ifndef NO_ASSERTIONS
  a_write_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && wr_req_r |-> reply_r == fpc_pkg::REPLY_NONE && !rst_req_r)
    else $error("page write result carries a reply or reset request");
  a_closed_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    pop && closed_nxt |=> done_r)
    else $error("closing packet did not mark the update done");
`endif

endmodule
`default_nettype wire

// File: rtl/firmware_packet_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware packet checker
// Checks firmware update frames (command patterns, sequence, CRC-16) and issues
// flash page writes, replies and reset requests.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                        Beat
//  in_bus    in   func, data_byte, last_byte, flash_ok           one byte or flash event
//  out_bus   out  reply_code, write_request, write_erase,        one result
//                 write_address, reset_request, update_closed
//  cfg_bus   in   start_address                                  one register write
//
//  One input beat is taken every cycle unless the queue is full; the payload
//  CRC is a combinational byte step in the front end: one byte per clock.
//  A frame end or flash event is written into the queue when accepted; the
//  sequencer pops it into the result registers, which raise out_bus.valid.
//  rst_n is synchronous; no clearing pass is needed after reset.
//  A stall on out_bus fills the two-entry queue, then drops in_bus.ready.
// ----------------------------------------------------------------------------
module firmware_packet_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  fpc_in_if.sink    in_bus,
  fpc_out_if.source out_bus,
  fpc_cfg_if.sink   cfg_bus
);

  logic              f_job_valid;
  fpc_pkg::fpc_job_t f_job;
  logic              q_full;
  logic              q_valid;
  fpc_pkg::fpc_job_t q_job;
  logic              q_pop;

  fpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .q_full    (q_full),
    .job_valid (f_job_valid),
    .job       (f_job)
  );

  fpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_job_valid),
    .push_job  (f_job),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  fpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_job),
    .pop       (q_pop),
    .out_bus   (out_bus),
    .cfg_bus   (cfg_bus)
  );

endmodule
`default_nettype wire

// File: dv/tb_firmware_packet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Firmware packet checker testbench
// Drives frame bytes and flash result events into the checker, predicts every
// reply, page write and reset request in a local model of the frame decoder and
// page sequencer, and compares each result beat against the oldest prediction.
// Directed tests cover the command frames, packet checks, address wrap,
// back-pressure and the final packet; a short random mix fills the rest.
// ----------------------------------------------------------------------------
module tb_firmware_packet_checker;

  localparam int unsigned RUN_LIMIT   = 500000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned IDLE_END    = 1000;

  localparam logic [79:0] INIT_FRAME = 80'h020E0102FA01012CDD03;
  localparam logic [79:0] ACT_FRAME  = 80'h020004AA000003;
  localparam logic [23:0] HDR_FRAME  = 24'h020107;

  typedef struct packed {
    fpc_pkg::reply_t reply;
    logic            wr_req;
    logic            wr_erase;
    logic [19:0]     wr_addr;
    logic            rst_req;
    logic            closed;
  } reply_beat_t;

  logic clk;
  logic rst_n;

  fpc_in_if  in_bus();
  fpc_out_if out_bus();
  fpc_cfg_if cfg_bus();

  firmware_packet_checker uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Predicted decoder and sequencer state.
  int unsigned rx_count;
  logic [15:0] pay_crc;
  logic [15:0] pkt_num;
  logic [15:0] remain_cnt;
  logic [15:0] rx_crc;
  logic [2:0]  pat_live;
  logic [15:0] next_pkt;
  logic [19:0] page_addr;
  int unsigned sector_pages;
  bit          image_done;
  bit          erase_pending;

  reply_beat_t awaited_replies[$];
  logic [7:0]  frame_buf[$];

  int unsigned error_count;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned pages_written;
  int unsigned cycle_count;
  bit          idle_on;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = {1'b0, c[15:1]} ^ 16'hA001;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

  task automatic predict_beat(input bit f, input logic [7:0] d, input bit lst, input bit ok);
    reply_beat_t r;
    int unsigned n;
    bit init_hit;
    bit act_hit;
    bit hdr_hit;
    r = '0;
    if (f) begin
      r.reply = ok ? fpc_pkg::REPLY_ACK : fpc_pkg::REPLY_REJ;
      if (!ok && erase_pending) begin
        sector_pages = 0;
      end
      erase_pending = 1'b0;
      awaited_replies.push_back(r);
    end else begin
      if (rx_count == 0) begin
        pay_crc    = 16'hFFFF;
        pat_live   = 3'b111;
        pkt_num    = '0;
        remain_cnt = '0;
        rx_crc     = '0;
      end
      if (rx_count < fpc_pkg::BUFFER_BYTES) begin
        if (rx_count < fpc_pkg::INIT_LEN) begin
          if (d != INIT_FRAME[8*(fpc_pkg::INIT_LEN-1-rx_count) +: 8]) pat_live[0] = 1'b0;
        end
        if (rx_count < fpc_pkg::ACT_LEN) begin
          if (d != ACT_FRAME[8*(fpc_pkg::ACT_LEN-1-rx_count) +: 8]) pat_live[1] = 1'b0;
        end
        if (rx_count < fpc_pkg::HDR_LEN) begin
          if (d != HDR_FRAME[8*(fpc_pkg::HDR_LEN-1-rx_count) +: 8]) pat_live[2] = 1'b0;
        end
        if (rx_count == 3) pkt_num[15:8] = d;
        if (rx_count == 4) pkt_num[7:0] = d;
        if (rx_count == 5) remain_cnt[15:8] = d;
        if (rx_count == 6) remain_cnt[7:0] = d;
        if (rx_count >= fpc_pkg::PAY_START && rx_count < fpc_pkg::CRC_POS) begin
          pay_crc = crc16_step(pay_crc, d);
        end
        if (rx_count == fpc_pkg::CRC_POS) rx_crc[15:8] = d;
        if (rx_count == fpc_pkg::CRC_POS + 1) rx_crc[7:0] = d;
        rx_count++;
      end
      if (lst) begin
        n = rx_count;
        rx_count = 0;
        init_hit = pat_live[0] && n >= fpc_pkg::INIT_LEN;
        act_hit  = pat_live[1] && n >= fpc_pkg::ACT_LEN;
        hdr_hit  = pat_live[2] && n >= fpc_pkg::HDR_LEN;
        if (init_hit) begin
          r.reply   = image_done ? fpc_pkg::REPLY_REJ : fpc_pkg::REPLY_NONE;
          r.rst_req = 1'b1;
        end else if (act_hit) begin
          if (image_done) begin
            r.reply   = fpc_pkg::REPLY_ACK;
            r.rst_req = 1'b1;
          end else begin
            r.reply = fpc_pkg::REPLY_REJ;
            sector_pages = 0;
          end
        end else if ((hdr_hit && pkt_num != next_pkt) || n < fpc_pkg::FRAME_MIN ||
                     rx_crc != pay_crc) begin
          r.reply = fpc_pkg::REPLY_REJ;
          sector_pages = 0;
        end else begin
          sector_pages++;
          r.wr_erase = (sector_pages == 1);
          if (sector_pages >= fpc_pkg::PAGES_PER_SECTOR) sector_pages = 0;
          erase_pending = r.wr_erase;
          r.wr_req  = 1'b1;
          r.wr_addr = page_addr;
          page_addr = page_addr + 20'd256;
          if (remain_cnt == 0) begin
            image_done = 1'b1;
            r.closed   = 1'b1;
          end
          next_pkt = next_pkt + 16'd1;
          pages_written++;
        end
        awaited_replies.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 100) begin
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Result checker: every accepted result beat against the oldest prediction.
  always @(posedge clk) begin : reply_check
    reply_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected result beat, reply_code", 32'(out_bus.reply_code), 32'd0);
      end else begin
        want = awaited_replies.pop_front();
        if (out_bus.reply_code !== want.reply)
          report_mismatch("reply_code", 32'(out_bus.reply_code), 32'(want.reply));
        if (out_bus.write_request !== want.wr_req)
          report_mismatch("write_request", 32'(out_bus.write_request), 32'(want.wr_req));
        if (out_bus.write_erase !== want.wr_erase)
          report_mismatch("write_erase", 32'(out_bus.write_erase), 32'(want.wr_erase));
        if (out_bus.write_address !== want.wr_addr)
          report_mismatch("write_address", 32'(out_bus.write_address), 32'(want.wr_addr));
        if (out_bus.reset_request !== want.rst_req)
          report_mismatch("reset_request", 32'(out_bus.reset_request), 32'(want.rst_req));
        if (out_bus.update_closed !== want.closed)
          report_mismatch("update_closed", 32'(out_bus.update_closed), 32'(want.closed));
      end
    end
  end

  // Result receiver: random stall bursts plus an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_bus.ready = 1'b0;
    end else begin
      out_bus.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_replies.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one beat, possibly after an idle gap, and waits for it to be taken.
  task automatic send_beat(input bit f, input logic [7:0] d, input bit lst, input bit ok);
    int unsigned gap;
    if (beats_sent >= IDLE_END) idle_on = 1'b0;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
    end
    @(negedge clk);
    in_bus.valid     = 1'b1;
    in_bus.func      = f;
    in_bus.data_byte = d;
    in_bus.last_byte = lst;
    in_bus.flash_ok  = ok;
    do @(posedge clk); while (!in_bus.ready);
    beats_sent++;
    predict_beat(f, d, lst, ok);
  endtask

  task automatic in_idle();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic send_flash(input bit ok);
    send_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ok);
  endtask

  // Sends frame_buf as one frame; a flash event is slipped in before byte flash_at.
  task automatic send_frame(input int flash_at);
    for (int i = 0; i < frame_buf.size(); i++) begin
      if (i == flash_at) send_flash(1'($urandom_range(0, 1)));
      send_beat(1'b0, frame_buf[i], i == frame_buf.size() - 1, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic load_packet(input logic [15:0] num, input logic [15:0] remain,
                             input bit bad_crc, input bit bad_hdr, input int keep_len);
    logic [15:0] c;
    logic [7:0]  b;
    frame_buf.delete();
    c = 16'hFFFF;
    frame_buf.push_back(bad_hdr ? 8'h12 : 8'h02);
    frame_buf.push_back(8'h01);
    frame_buf.push_back(8'h07);
    frame_buf.push_back(num[15:8]);
    frame_buf.push_back(num[7:0]);
    frame_buf.push_back(remain[15:8]);
    frame_buf.push_back(remain[7:0]);
    for (int i = 0; i < fpc_pkg::PAGE_BYTES; i++) begin
      b = 8'($urandom_range(0, 255));
      c = crc16_step(c, b);
      frame_buf.push_back(b);
    end
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frame_buf.push_back(c[15:8]);
    frame_buf.push_back(c[7:0]);
    while (keep_len > 0 && frame_buf.size() > keep_len) void'(frame_buf.pop_back());
  endtask

  // Builds a command frame of len bytes; bytes past the pattern are random.
  task automatic load_command(input logic [79:0] pat, input int pat_len, input int len,
                              input bit corrupt);
    int pos;
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      if (i < pat_len) frame_buf.push_back(pat[8*(pat_len-1-i) +: 8]);
      else frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    if (corrupt) begin
      pos = int'($urandom_range(0, ((len < pat_len) ? len : pat_len) - 1));
      frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
    end
  endtask

  task automatic load_noise(input int len);
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) frame_buf[0] = 8'h02;
  endtask

  task automatic write_start_address(input logic [19:0] addr);
    in_idle();
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid         = 1'b1;
    cfg_bus.start_address = addr;
    do @(posedge clk); while (!cfg_bus.ready);
    page_addr = addr;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic test_commands();
    load_command(INIT_FRAME, fpc_pkg::INIT_LEN, fpc_pkg::INIT_LEN, 1'b0);
    send_frame(-1);
    load_command(ACT_FRAME, fpc_pkg::ACT_LEN, fpc_pkg::ACT_LEN, 1'b0);
    send_frame(-1);
    load_command(INIT_FRAME, fpc_pkg::INIT_LEN, fpc_pkg::INIT_LEN, 1'b1);
    send_frame(-1);
    load_command(ACT_FRAME, fpc_pkg::ACT_LEN, fpc_pkg::ACT_LEN, 1'b1);
    send_frame(-1);
    // Trailing bytes after a full pattern still match it.
    load_command(INIT_FRAME, fpc_pkg::INIT_LEN, fpc_pkg::INIT_LEN + 3, 1'b0);
    send_frame(-1);
    // Truncated patterns count as a mismatch.
    load_command(ACT_FRAME, fpc_pkg::ACT_LEN, fpc_pkg::ACT_LEN - 1, 1'b0);
    send_frame(-1);
    load_command(INIT_FRAME, fpc_pkg::INIT_LEN, 1, 1'b0);
    send_frame(-1);
    in_idle();
  endtask

  task automatic test_packet_checks();
    // A failed erase write after an accepted page restarts the sector group.
    load_packet(next_pkt, 16'hFFFF, 1'b0, 1'b0, 0);
    send_frame(-1);
    send_flash(1'b0);
    // A header frame with an out-of-sequence packet number is rejected.
    load_packet(16'hFFFF, 16'h0005, 1'b0, 1'b0, 9);
    send_frame(-1);
    // A CRC mismatch, with a flash event slipped into the middle of the frame.
    load_packet(next_pkt, 16'h0005, 1'b1, 1'b0, 0);
    send_frame(120);
    in_idle();
  endtask

  task automatic test_address_wrap();
    // The page after the top of flash wraps to the bottom.
    write_start_address(20'hFFFFF);
    load_packet(next_pkt, 16'h0003, 1'b0, 1'b0, 0);
    send_frame(-1);
    send_flash(1'b1);
    in_idle();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_flash(1'($urandom_range(0, 1)));
    repeat (3) begin
      load_noise(int'($urandom_range(1, 4)));
      send_frame(-1);
    end
    in_idle();
  endtask

  task automatic test_final_packet();
    load_packet(next_pkt, 16'h0000, 1'b0, 1'b0, 0);
    send_frame(-1);
    send_flash(1'b1);
    load_command(INIT_FRAME, fpc_pkg::INIT_LEN, fpc_pkg::INIT_LEN, 1'b0);
    send_frame(-1);
    load_command(ACT_FRAME, fpc_pkg::ACT_LEN, fpc_pkg::ACT_LEN, 1'b0);
    send_frame(-1);
    in_idle();
  endtask

  task automatic test_random_mix();
    int pick;
    int keep;
    while (beats_sent < ITEM_TARGET) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 35) begin
        // Full packets only while the item budget has room for one.
        if (beats_sent + fpc_pkg::FRAME_MIN + 2 > ITEM_TARGET) begin
          keep = int'($urandom_range(1, 14));
        end else if ($urandom_range(0, 9) == 0) begin
          keep = int'($urandom_range(1, fpc_pkg::FRAME_MIN - 1));
        end else begin
          keep = 0;
        end
        load_packet(($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF)) : next_pkt,
                    ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(0, 16'hFFFF)),
                    $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0, keep);
        send_frame(($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8)) : -1);
        send_flash($urandom_range(0, 3) != 0);
      end else if (pick < 50) begin
        load_command(INIT_FRAME, fpc_pkg::INIT_LEN,
                     ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 14)) :
                                                   fpc_pkg::INIT_LEN,
                     $urandom_range(0, 3) == 0);
        send_frame(-1);
      end else if (pick < 65) begin
        load_command(ACT_FRAME, fpc_pkg::ACT_LEN,
                     ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 10)) :
                                                   fpc_pkg::ACT_LEN,
                     $urandom_range(0, 3) == 0);
        send_frame(-1);
      end else if (pick < 80) begin
        send_flash(1'($urandom_range(0, 1)));
      end else begin
        load_noise(int'($urandom_range(1, 14)));
        send_frame(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : -1);
      end
    end
    in_idle();
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.func           = 1'b0;
    in_bus.data_byte      = 8'h00;
    in_bus.last_byte      = 1'b0;
    in_bus.flash_ok       = 1'b0;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.start_address = '0;
    error_count   = 0;
    beats_sent    = 0;
    results_seen  = 0;
    pages_written = 0;
    cycle_count   = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    hold_left     = 0;
    stall_left    = 0;
    rx_count      = 0;
    pay_crc       = 16'hFFFF;
    pkt_num       = '0;
    remain_cnt    = '0;
    rx_crc        = '0;
    pat_live      = 3'b111;
    next_pkt      = 16'd1;
    page_addr     = '0;
    sector_pages  = 0;
    image_done    = 1'b0;
    erase_pending = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_commands();
    test_packet_checks();
    test_address_wrap();
    test_backpressure();
    test_final_packet();
    test_random_mix();

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d input beats, %0d result beats, %0d page writes, %0d mismatches",
             beats_sent, results_seen, pages_written, error_count);
    $display("summary: commands, sequence and CRC checks, address wrap, back-pressure, %s",
             "final packet and a random mix");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/fpc_pkg.sv
rtl/fpc_if.sv
rtl/fpc_front.sv
rtl/fpc_queue.sv
rtl/fpc_back.sv
rtl/firmware_packet_checker.sv
dv/tb_firmware_packet_checker.sv
